### sv/srm_pkg.sv
package srm_pkg;

   localparam int MAX_ROWS = 8;
   localparam int MAX_COLS = 8;
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int DIM_W    = 4;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int IDX_W    = 1;
   localparam int RSP_W    = 40;

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] REG_ROW_COUNT = 1'd0;
   localparam logic [IDX_W-1:0] REG_COL_COUNT = 1'd1;

   typedef enum logic [1:0] {
      LD_LOAD,
      LD_DIVIDE,
      LD_WAIT
   } ld_state_type;

   typedef enum logic [1:0] {
      PH_TOP,
      PH_RIGHT,
      PH_BOTTOM,
      PH_LEFT
   } phase_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } wr_req_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic              last;
   } rd_req_type;

endpackage

### sv/srm_ram.sv
module srm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // The read register holds its word until the next read.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/srm_loader.sv
module srm_loader (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cfg_we,
   input  logic [srm_pkg::DIM_W-1:0]    cols,
   input  logic [srm_pkg::CNT_W-1:0]    total,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [srm_pkg::DATA_W-1:0]   req_data,
   input  logic                         spiral_done,
   output srm_pkg::wr_req_type          wr_req,
   output logic                         start
);

   srm_pkg::ld_state_type state_ff, state_in;

   logic [srm_pkg::ADDR_W-1:0] load_count_ff, load_count_in;
   logic [srm_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [srm_pkg::COL_W-1:0]  col_ff, col_in;
   logic [2:0]                 div_step_ff, div_step_in;
   logic [srm_pkg::COL_W-1:0]  div_rem_ff, div_rem_in;
   logic [srm_pkg::ROW_W-1:0]  div_quo_ff, div_quo_in;

   logic                        accept;
   logic                        wrap;
   logic [srm_pkg::ROW_W-1:0]   pos_row;
   logic [srm_pkg::COL_W-1:0]   pos_col;
   logic [srm_pkg::CNT_W-1:0]   pos_next;
   logic [srm_pkg::COL_W:0]     col_next;
   logic [srm_pkg::DIM_W-1:0]   trial;
   logic                        trial_ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srm_pkg::LD_LOAD;
         load_count_ff <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         div_step_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         div_step_ff   <= div_step_in;
      end
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
   end

   assign accept   = req_valid && req_ready;
   assign wrap     = srm_pkg::CNT_W'(load_count_ff) >= total;
   assign pos_row  = wrap ? '0 : row_ff;
   assign pos_col  = wrap ? '0 : col_ff;
   assign pos_next = (wrap ? '0 : srm_pkg::CNT_W'(load_count_ff)) + srm_pkg::CNT_W'(1);
   assign col_next = {1'b0, pos_col} + (srm_pkg::COL_W+1)'(1);

   // Restoring division of the load count by the column count, one quotient
   // bit per cycle, to find the load position again after a dimension change.
   assign trial    = {div_rem_ff, load_count_ff[div_step_ff]};
   assign trial_ge = trial >= cols;

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      div_step_in   = div_step_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      req_ready     = 1'b0;
      start         = 1'b0;
      wr_req.en     = 1'b0;
      wr_req.addr   = srm_pkg::ADDR_W'(pos_row) * srm_pkg::ADDR_W'(srm_pkg::MAX_COLS)
                      + srm_pkg::ADDR_W'(pos_col);
      wr_req.data   = req_data;

      case (state_ff)
         srm_pkg::LD_LOAD: begin
            req_ready = 1'b1;
            if (accept) begin
               wr_req.en = 1'b1;
               if (pos_next == total) begin
                  load_count_in = '0;
                  row_in        = '0;
                  col_in        = '0;
                  start         = 1'b1;
                  state_in      = srm_pkg::LD_WAIT;
               end else begin
                  load_count_in = pos_next[srm_pkg::ADDR_W-1:0];
                  if (col_next == srm_pkg::DIM_W'(cols)) begin
                     col_in = '0;
                     row_in = pos_row + srm_pkg::ROW_W'(1);
                  end else begin
                     col_in = col_next[srm_pkg::COL_W-1:0];
                     row_in = pos_row;
                  end
               end
            end
         end
         srm_pkg::LD_DIVIDE: begin
            div_quo_in = {div_quo_ff[srm_pkg::ROW_W-2:0], trial_ge};
            div_rem_in = trial_ge ? srm_pkg::COL_W'(trial - cols)
                                  : trial[srm_pkg::COL_W-1:0];
            if (div_step_ff == '0) begin
               row_in   = div_quo_in;
               col_in   = div_rem_in;
               state_in = srm_pkg::LD_LOAD;
            end else begin
               div_step_in = div_step_ff - 3'd1;
            end
         end
         srm_pkg::LD_WAIT: begin
            if (spiral_done) begin
               state_in = srm_pkg::LD_LOAD;
            end
         end
         default: begin
            state_in = srm_pkg::LD_LOAD;
         end
      endcase

      // A register write restarts the position search, unless the loader is waiting for the walk.
      if (cfg_we && state_ff != srm_pkg::LD_WAIT) begin
         state_in    = srm_pkg::LD_DIVIDE;
         div_step_in = 3'(srm_pkg::ADDR_W - 1);
         div_rem_in  = '0;
         div_quo_in  = '0;
      end
   end

endmodule

### sv/srm_spiral.sv
module srm_spiral (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [srm_pkg::DIM_W-1:0] rows,
   input  logic [srm_pkg::DIM_W-1:0] cols,
   input  logic [srm_pkg::CNT_W-1:0] total,
   input  logic                      issue_ok,
   output srm_pkg::rd_req_type       rd_req,
   output logic                      busy,
   output logic                      done
);

   logic                      active_ff, active_in;
   srm_pkg::phase_type        phase_ff, phase_in;
   logic [srm_pkg::ROW_W-1:0] ring_ff, ring_in;
   logic [srm_pkg::ROW_W-1:0] idx_ff, idx_in;
   logic [srm_pkg::CNT_W-1:0] count_ff, count_in;

   logic [srm_pkg::ROW_W-1:0] end_r;
   logic [srm_pkg::COL_W-1:0] end_c;
   logic [srm_pkg::ROW_W-1:0] row;
   logic [srm_pkg::COL_W-1:0] col;
   logic                      issue;
   logic                      last;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      phase_ff <= phase_in;
      ring_ff  <= ring_in;
      idx_ff   <= idx_in;
      count_ff <= count_in;
   end

   assign end_r = srm_pkg::ROW_W'(rows - srm_pkg::DIM_W'(1)) - ring_ff;
   assign end_c = srm_pkg::COL_W'(cols - srm_pkg::DIM_W'(1)) - ring_ff;
   assign issue = active_ff && issue_ok;
   assign last  = count_ff == total - srm_pkg::CNT_W'(1);
   assign busy  = active_ff;
   assign done  = issue && last;

   always_comb begin
      case (phase_ff)
         srm_pkg::PH_TOP:    begin row = ring_ff; col = idx_ff;  end
         srm_pkg::PH_RIGHT:  begin row = idx_ff;  col = end_c;   end
         srm_pkg::PH_BOTTOM: begin row = end_r;   col = idx_ff;  end
         srm_pkg::PH_LEFT:   begin row = idx_ff;  col = ring_ff; end
         default:            begin row = ring_ff; col = idx_ff;  end
      endcase
   end

   always_comb begin
      rd_req.en   = issue;
      rd_req.addr = srm_pkg::ADDR_W'(row) * srm_pkg::ADDR_W'(srm_pkg::MAX_COLS)
                    + srm_pkg::ADDR_W'(col);
      rd_req.row  = row;
      rd_req.col  = col;
      rd_req.last = last;
   end

   // Walk one position per issued read; a side that ends moves on to the next
   // side, and a ring whose closing sides are empty moves on to the next ring.
   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      ring_in   = ring_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;

      if (start) begin
         active_in = 1'b1;
         phase_in  = srm_pkg::PH_TOP;
         ring_in   = '0;
         idx_in    = '0;
         count_in  = '0;
      end else if (issue) begin
         count_in = count_ff + srm_pkg::CNT_W'(1);
         if (last) begin
            active_in = 1'b0;
         end
         case (phase_ff)
            srm_pkg::PH_TOP: begin
               if (idx_ff != end_c) begin
                  idx_in = idx_ff + srm_pkg::ROW_W'(1);
               end else if (end_r > ring_ff) begin
                  phase_in = srm_pkg::PH_RIGHT;
                  idx_in   = ring_ff + srm_pkg::ROW_W'(1);
               end else begin
                  ring_in = ring_ff + srm_pkg::ROW_W'(1);
                  idx_in  = ring_ff + srm_pkg::ROW_W'(1);
               end
            end
            srm_pkg::PH_RIGHT: begin
               if (idx_ff != end_r) begin
                  idx_in = idx_ff + srm_pkg::ROW_W'(1);
               end else if (end_c > ring_ff) begin
                  phase_in = srm_pkg::PH_BOTTOM;
                  idx_in   = end_c - srm_pkg::COL_W'(1);
               end else begin
                  phase_in = srm_pkg::PH_TOP;
                  ring_in  = ring_ff + srm_pkg::ROW_W'(1);
                  idx_in   = ring_ff + srm_pkg::ROW_W'(1);
               end
            end
            srm_pkg::PH_BOTTOM: begin
               if (idx_ff != ring_ff) begin
                  idx_in = idx_ff - srm_pkg::COL_W'(1);
               end else if (end_r > ring_ff + srm_pkg::ROW_W'(1)) begin
                  phase_in = srm_pkg::PH_LEFT;
                  idx_in   = end_r - srm_pkg::ROW_W'(1);
               end else begin
                  phase_in = srm_pkg::PH_TOP;
                  ring_in  = ring_ff + srm_pkg::ROW_W'(1);
                  idx_in   = ring_ff + srm_pkg::ROW_W'(1);
               end
            end
            srm_pkg::PH_LEFT: begin
               if (idx_ff != ring_ff + srm_pkg::ROW_W'(1)) begin
                  idx_in = idx_ff - srm_pkg::ROW_W'(1);
               end else begin
                  phase_in = srm_pkg::PH_TOP;
                  ring_in  = ring_ff + srm_pkg::ROW_W'(1);
                  idx_in   = ring_ff + srm_pkg::ROW_W'(1);
               end
            end
            default: begin
               phase_in = srm_pkg::PH_TOP;
            end
         endcase
      end
   end

endmodule

### sv/spiral_order_matrix_reader.sv
// Spiral-order matrix reader. Requests carry one signed 32-bit element each, in
// row-major order, for a matrix of row_count by col_count (csr index 0 and 1,
// each taken as 1..8). Loading takes one request per cycle into a 64-word
// single-port-read RAM. The request that completes the matrix starts a walk
// that reads the RAM once per cycle, unless the output stalls, and returns
// every element in clockwise spiral order, with its row and column and tlast
// on the final one; each read word passes through the RAM read register and
// the output register, and no request is taken until every read has been
// issued. After a register write, unless it comes while the loader waits for
// the walk, the block recovers the load position with a bit-serial divide by
// the column count, and takes no request then.
module spiral_order_matrix_reader (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [srm_pkg::DATA_W-1:0]       req_tdata,  // [31:0] element
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [srm_pkg::RSP_W-1:0]        rsp_tdata,  // [31:0] value, [34:32] row_index,
                                                        // [37:35] col_index, [39:38] zero
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [srm_pkg::IDX_W-1:0]        csr_index,
   input  logic [srm_pkg::DIM_W-1:0]        csr_wdata
);

   logic [srm_pkg::DIM_W-1:0] row_count_ff, row_count_in;
   logic [srm_pkg::DIM_W-1:0] col_count_ff, col_count_in;

   logic [srm_pkg::DIM_W-1:0] rows;
   logic [srm_pkg::DIM_W-1:0] cols;
   logic [srm_pkg::CNT_W-1:0] total;

   srm_pkg::wr_req_type        wr_req;
   srm_pkg::rd_req_type        rd_req;
   logic                       start;
   logic                       spiral_busy;
   logic                       spiral_done;
   logic                       issue_ok;
   logic [srm_pkg::DATA_W-1:0] rd_data;

   logic                      pend_ff, pend_in;
   logic [srm_pkg::ROW_W-1:0] pend_row_ff, pend_row_in;
   logic [srm_pkg::COL_W-1:0] pend_col_ff, pend_col_in;
   logic                      pend_last_ff, pend_last_in;

   logic                       out_valid_ff, out_valid_in;
   logic [srm_pkg::DATA_W-1:0] out_value_ff, out_value_in;
   logic [srm_pkg::ROW_W-1:0]  out_row_ff, out_row_in;
   logic [srm_pkg::COL_W-1:0]  out_col_ff, out_col_in;
   logic                       out_last_ff, out_last_in;
   logic                       move;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= srm_pkg::DIM_W'(srm_pkg::MAX_ROWS);
         col_count_ff <= srm_pkg::DIM_W'(srm_pkg::MAX_COLS);
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      pend_row_ff  <= pend_row_in;
      pend_col_ff  <= pend_col_in;
      pend_last_ff <= pend_last_in;
      out_value_ff <= out_value_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_last_ff  <= out_last_in;
   end

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_we) begin
         case (csr_index)
            srm_pkg::REG_ROW_COUNT: row_count_in = csr_wdata;
            srm_pkg::REG_COL_COUNT: col_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // A zero dimension counts as one, and a dimension above the maximum is held
   // at the maximum.
   always_comb begin
      if (row_count_ff == '0) begin
         rows = srm_pkg::DIM_W'(1);
      end else if (row_count_ff > srm_pkg::DIM_W'(srm_pkg::MAX_ROWS)) begin
         rows = srm_pkg::DIM_W'(srm_pkg::MAX_ROWS);
      end else begin
         rows = row_count_ff;
      end
      if (col_count_ff == '0) begin
         cols = srm_pkg::DIM_W'(1);
      end else if (col_count_ff > srm_pkg::DIM_W'(srm_pkg::MAX_COLS)) begin
         cols = srm_pkg::DIM_W'(srm_pkg::MAX_COLS);
      end else begin
         cols = col_count_ff;
      end
      total = srm_pkg::CNT_W'(rows) * srm_pkg::CNT_W'(cols);
   end

   srm_loader u_loader (
      .clock       (clock),
      .reset       (reset),
      .cfg_we      (csr_we),
      .cols        (cols),
      .total       (total),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_data    (req_tdata),
      .spiral_done (spiral_done),
      .wr_req      (wr_req),
      .start       (start)
   );

   srm_spiral u_spiral (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .rows     (rows),
      .cols     (cols),
      .total    (total),
      .issue_ok (issue_ok),
      .rd_req   (rd_req),
      .busy     (spiral_busy),
      .done     (spiral_done)
   );

   srm_ram #(
      .WIDTH (srm_pkg::DATA_W),
      .DEPTH (srm_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_req.en),
      .wr_addr (wr_req.addr),
      .wr_data (wr_req.data),
      .rd_en   (rd_req.en),
      .rd_addr (rd_req.addr),
      .rd_data (rd_data)
   );

   // The RAM read register holds a word until it moves to the output register,
   // so it doubles as a skid stage behind the output.
   assign move     = pend_ff && (!out_valid_ff || rsp_tready);
   assign issue_ok = !pend_ff || move;

   always_comb begin
      pend_in      = pend_ff;
      pend_row_in  = pend_row_ff;
      pend_col_in  = pend_col_ff;
      pend_last_in = pend_last_ff;
      if (rd_req.en) begin
         pend_in      = 1'b1;
         pend_row_in  = rd_req.row;
         pend_col_in  = rd_req.col;
         pend_last_in = rd_req.last;
      end else if (move) begin
         pend_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_last_in  = out_last_ff;
      if (move) begin
         out_valid_in = 1'b1;
         out_value_in = rd_data;
         out_row_in   = pend_row_ff;
         out_col_in   = pend_col_ff;
         out_last_in  = pend_last_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_col_ff, out_row_ff, out_value_ff};
   assign rsp_tlast  = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready && spiral_busy))
      else $error("request accepted while the spiral walk is running");

   assert property (@(posedge clock) disable iff (reset)
      rd_req.en |-> (!pend_ff || move))
      else $error("RAM read issued over a word that has not moved out");

   assert property (@(posedge clock) disable iff (reset)
      spiral_done |=> !spiral_busy)
      else $error("spiral walk still running after its final read");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("waiting result changed before it was taken");

endmodule
